// ===== rtl/wbal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wbal_pkg;

  localparam int NCH       = 3;   // blue, green, red
  localparam int PIX_W     = 8;
  localparam int PROD_W    = 2 * PIX_W;
  localparam int DIV_STEPS = PIX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [PIX_W-1:0] PIX_MAX  = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] PIX_ZERO = '0;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    ACT_MEASURE = 2'd0,
    ACT_CORRECT = 2'd1,
    ACT_END     = 2'd2
  } action_t;

  typedef struct packed {
    logic [1:0] action;
    pix_t       blue_in;
    pix_t       green_in;
    pix_t       red_in;
  } in_item_t;

  typedef struct packed {
    pix_t blue_out;
    pix_t green_out;
    pix_t red_out;
  } out_item_t;

  // one correct item with the latched maxima it was accepted against
  typedef struct packed {
    pix_t [NCH-1:0] pix;
    pix_t [NCH-1:0] chmax;
    pix_t           overall;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_PREP,
    ST_DIV,
    ST_HOLD
  } back_state_t;

  typedef struct packed {
    logic deq;
    logic load_work;
    logic do_mult;
    logic do_prep;
    logic do_step;
    logic do_out;
  } back_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/max_rgb_white_balance_core.sv =====
// White-patch (max-RGB) white balance for 8-bit blue/green/red pixels.
// Input queue: drive in_item and raise push; the item transfers on a
// clock edge where push is high and full is low. Action measure folds the
// pixel into per-channel running maxima, action end latches those maxima
// and clears the running ones, action correct produces one result.
// Measure and end items are absorbed in the cycle they transfer.
// Result queue: while empty is low, out_item holds the oldest result; it
// transfers on an edge where pop is high. Each correct item yields
// floor(pixel * overall_max / channel_max) per channel, saturated at 255,
// or the pixel itself where that channel's latched maximum is zero.
// Correct items are captured with the maxima in force when they transfer
// and wait in a short queue for a shared multiply / restoring-divide unit.
// That unit works on one correct item at a time (dequeue, 8-bit multiply,
// setup, 8 one-bit divide steps, output load) and takes the next one only
// once the result is loaded; measure and end items go at one per cycle
// while the queue has room. A stalled receiver fills the output register,
// then the queue, then full rises. Synchronous reset clears all maxima
// (every channel passes through) and empties both queues.
`timescale 1ns / 1ps
`default_nettype none

module max_rgb_white_balance_core #(
  parameter int QUEUE_DEPTH = wbal_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire wbal_pkg::in_item_t  in_item,
  output logic                     empty,
  input  wire logic                pop,
  output wbal_pkg::out_item_t      out_item
);

  logic            q_push, q_full, q_pop, q_empty;
  wbal_pkg::work_t q_wr_data, q_rd_data;

  assign full = q_full;

  wbal_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wr_data)
  );

  wbal_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  wbal_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_data   (q_rd_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ===== rtl/wbal_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbal_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire wbal_pkg::in_item_t in_item,
  input  wire logic              q_full,
  output logic                   q_push,
  output wbal_pkg::work_t        q_data
);

  wbal_pkg::pix_t [wbal_pkg::NCH-1:0] running_r, running_nxt;
  wbal_pkg::pix_t [wbal_pkg::NCH-1:0] latched_r, latched_nxt;
  wbal_pkg::pix_t [wbal_pkg::NCH-1:0] pix;
  wbal_pkg::pix_t                     ovr_bg;
  logic                               accept;

  assign pix[0] = in_item.blue_in;
  assign pix[1] = in_item.green_in;
  assign pix[2] = in_item.red_in;

  assign accept = push && !q_full;

  always_comb begin
    running_nxt = running_r;
    latched_nxt = latched_r;
    q_push      = 1'b0;
    if (accept) begin
      unique case (in_item.action)
        wbal_pkg::ACT_MEASURE: begin
          for (int c = 0; c < wbal_pkg::NCH; c++) begin
            running_nxt[c] = (pix[c] > running_r[c]) ? pix[c] : running_r[c];
          end
        end
        wbal_pkg::ACT_END: begin
          latched_nxt = running_r;
          running_nxt = '0;
        end
        wbal_pkg::ACT_CORRECT: begin
          q_push = 1'b1;
        end
        default: begin
          // unused code: drop
        end
      endcase
    end
  end

  assign ovr_bg = (latched_r[0] > latched_r[1]) ? latched_r[0] : latched_r[1];

  always_comb begin
    q_data.pix     = pix;
    q_data.chmax   = latched_r;
    q_data.overall = (ovr_bg > latched_r[2]) ? ovr_bg : latched_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      latched_r <= '0;
    end else begin
      running_r <= running_nxt;
      latched_r <= latched_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wbal_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbal_queue #(
  parameter int DEPTH = wbal_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire wbal_pkg::work_t wr_data,
  output logic                 full,
  input  wire logic            pop,
  output wbal_pkg::work_t      rd_data,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wbal_pkg::work_t   mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wbal_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wbal_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire wbal_pkg::work_t    q_data,
  output logic                    q_pop,
  output logic                    empty,
  input  wire logic               pop,
  output wbal_pkg::out_item_t     out_item
);

  localparam int NCH   = wbal_pkg::NCH;
  localparam int PIX_W = wbal_pkg::PIX_W;

  wbal_pkg::back_state_t state_r, state_nxt;
  wbal_pkg::back_ctl_t   ctl;

  wbal_pkg::pix_t [NCH-1:0]          pix_r;
  wbal_pkg::pix_t [NCH-1:0]          chmax_r;
  wbal_pkg::pix_t                    ovr_r;
  logic [NCH-1:0][wbal_pkg::PROD_W-1:0] prod_r;
  wbal_pkg::pix_t [NCH-1:0]          rem_r;
  wbal_pkg::pix_t [NCH-1:0]          low_r;
  wbal_pkg::pix_t [NCH-1:0]          quo_r;
  logic [NCH-1:0]                    sat_r;
  logic [wbal_pkg::CNT_W-1:0]        cnt_r;
  wbal_pkg::out_item_t               out_item_r;
  logic                              out_valid_r;
  logic                              out_free;

  logic [NCH-1:0][PIX_W:0]           trial;
  logic [NCH-1:0]                    qbit;
  wbal_pkg::pix_t [NCH-1:0]          rem_step;
  wbal_pkg::pix_t [NCH-1:0]          res;

  assign out_free = !out_valid_r || pop;
  assign empty    = !out_valid_r;
  assign out_item = out_item_r;
  assign q_pop    = ctl.deq;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wbal_pkg::ST_IDLE: if (!q_empty) state_nxt = wbal_pkg::ST_MULT;
      wbal_pkg::ST_MULT: state_nxt = wbal_pkg::ST_PREP;
      wbal_pkg::ST_PREP: state_nxt = wbal_pkg::ST_DIV;
      wbal_pkg::ST_DIV:  if (cnt_r == wbal_pkg::LAST_STEP) state_nxt = wbal_pkg::ST_HOLD;
      wbal_pkg::ST_HOLD: if (out_free) state_nxt = wbal_pkg::ST_IDLE;
      default:           state_nxt = wbal_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      wbal_pkg::ST_IDLE: begin
        ctl.deq       = !q_empty;
        ctl.load_work = !q_empty;
      end
      wbal_pkg::ST_MULT: ctl.do_mult = 1'b1;
      wbal_pkg::ST_PREP: ctl.do_prep = 1'b1;
      wbal_pkg::ST_DIV:  ctl.do_step = 1'b1;
      wbal_pkg::ST_HOLD: ctl.do_out  = out_free;
      default: ;
    endcase
  end

  // one restoring step per channel; the remainder stays below chmax unless sat_r is set
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      trial[c]    = {rem_r[c], low_r[c][PIX_W-1]};
      qbit[c]     = (trial[c] >= {1'b0, chmax_r[c]});
      rem_step[c] = qbit[c] ? PIX_W'(trial[c] - {1'b0, chmax_r[c]})
                            : trial[c][PIX_W-1:0];
      if (chmax_r[c] == wbal_pkg::PIX_ZERO) begin
        res[c] = pix_r[c];
      end else if (sat_r[c]) begin
        res[c] = wbal_pkg::PIX_MAX;
      end else begin
        res[c] = quo_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wbal_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (ctl.do_out) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
      if (ctl.do_prep) begin
        cnt_r <= '0;
      end else if (ctl.do_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_work) begin
      pix_r   <= q_data.pix;
      chmax_r <= q_data.chmax;
      ovr_r   <= q_data.overall;
    end
    for (int c = 0; c < NCH; c++) begin
      if (ctl.do_mult) begin
        prod_r[c] <= {{PIX_W{1'b0}}, pix_r[c]} * {{PIX_W{1'b0}}, ovr_r};
      end
      if (ctl.do_prep) begin
        // quotient reaches 256 exactly when the high byte is at least chmax
        sat_r[c] <= (prod_r[c][wbal_pkg::PROD_W-1:PIX_W] >= chmax_r[c]);
        rem_r[c] <= prod_r[c][wbal_pkg::PROD_W-1:PIX_W];
        low_r[c] <= prod_r[c][PIX_W-1:0];
        quo_r[c] <= '0;
      end else if (ctl.do_step) begin
        rem_r[c] <= rem_step[c];
        low_r[c] <= {low_r[c][PIX_W-2:0], 1'b0};
        quo_r[c] <= {quo_r[c][PIX_W-2:0], qbit[c]};
      end
    end
    if (ctl.do_out) begin
      out_item_r.blue_out  <= res[0];
      out_item_r.green_out <= res[1];
      out_item_r.red_out   <= res[2];
    end
  end

endmodule

`default_nettype wire
